/* design/nfcs_pkg.sv */
// ----------------------------------------------------------------------------
// NOR flash command sequencer package
// Shared types, command codes and the burst step table.
// ----------------------------------------------------------------------------
`default_nettype none

package nfcs_pkg;

  // Field widths of the stream payloads.
  localparam int FLASH_ADDR_W = 24;
  localparam int WORD_W       = 16;
  localparam int BLOCK_W      = 8;
  localparam int SHIFT_W      = 5;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 3;
  localparam int STEP_W       = 3;

  // Defaults for the top-level parameters.
  localparam int ADDR_BITS_DEFAULT   = 24;
  localparam int BLOCK_COUNT_DEFAULT = 256;

  // Number of decoded requests that may wait between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_FLASH_BASE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SHIFT = 1'd1;
  localparam logic [SHIFT_W-1:0]     BLOCK_SHIFT_RESET = 5'd15;

  // Request codes.
  localparam logic [OP_W-1:0] OP_UNLOCK     = 3'd0;
  localparam logic [OP_W-1:0] OP_PROGRAM    = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE      = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_REPLY = 3'd3;
  localparam logic [OP_W-1:0] OP_RESUME     = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_WORKING   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SUSPENDED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_VALID = 3'd4;

  // Flash command bytes.
  localparam logic [7:0] CMD_LOCK_SETUP   = 8'h60;
  localparam logic [7:0] CMD_CONFIRM      = 8'hD0;
  localparam logic [7:0] CMD_CLEAR_STATUS = 8'h50;
  localparam logic [7:0] CMD_PROGRAM      = 8'h40;
  localparam logic [7:0] CMD_ERASE        = 8'h20;
  localparam logic [7:0] CMD_READ_STATUS  = 8'h70;
  localparam logic [7:0] CMD_SUSPEND      = 8'hB0;
  localparam logic [7:0] CMD_READ_ARRAY   = 8'hFF;

  // Status register bits.
  localparam int SR_READY_BIT   = 7;
  localparam int SR_SUSPEND_BIT = 6;

  // Sequencer phase, one-hot.
  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_PROG_CHECK = 6'b000010,
    PH_PROG_POLL  = 6'b000100,
    PH_ERASE_POLL = 6'b001000,
    PH_SUSP_POLL  = 6'b010000,
    PH_SUSPENDED  = 6'b100000
  } phase_t;

  // Kind of bus burst that one accepted item causes.
  typedef enum logic [3:0] {
    K_BAD       = 4'd0,
    K_UNLOCK    = 4'd1,
    K_ERASE     = 4'd2,
    K_PROG_READ = 4'd3,
    K_REJECT    = 4'd4,
    K_PROG_WR   = 4'd5,
    K_DONE      = 4'd6,
    K_POLL      = 4'd7,
    K_SUSPEND   = 4'd8,
    K_SUSP_HOLD = 4'd9,
    K_RESUME    = 4'd10
  } burst_kind_t;

  // Unpacked input item.
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [FLASH_ADDR_W-1:0] word_address;
    logic [WORD_W-1:0]       write_value;
    logic [BLOCK_W-1:0]      block_number;
    logic [WORD_W-1:0]       read_data;
    logic                    irq_pending;
  } in_item_t;

  // Decoded request handed from front to back.
  typedef struct packed {
    burst_kind_t             kind;
    logic [FLASH_ADDR_W-1:0] address;
    logic [WORD_W-1:0]       value;
  } burst_t;

  // One result of a burst.
  typedef struct packed {
    logic                has_access;
    logic                is_write;
    logic                use_value;
    logic [7:0]          cmd;
    logic [STATUS_W-1:0] status;
    logic                last;
  } step_t;

  function automatic step_t step_write(input logic [7:0] cmd, input logic last,
                                       input logic [STATUS_W-1:0] status);
    step_t s;
    s = '{has_access: 1'b1, is_write: 1'b1, use_value: 1'b0, cmd: cmd,
          status: status, last: last};
    return s;
  endfunction

  function automatic step_t step_value();
    step_t s;
    s = '{has_access: 1'b1, is_write: 1'b1, use_value: 1'b1, cmd: 8'h00,
          status: ST_WORKING, last: 1'b0};
    return s;
  endfunction

  function automatic step_t step_read();
    step_t s;
    s = '{has_access: 1'b1, is_write: 1'b0, use_value: 1'b0, cmd: 8'h00,
          status: ST_WORKING, last: 1'b1};
    return s;
  endfunction

  function automatic step_t step_status(input logic [STATUS_W-1:0] status);
    step_t s;
    s = '{has_access: 1'b0, is_write: 1'b0, use_value: 1'b0, cmd: 8'h00,
          status: status, last: 1'b1};
    return s;
  endfunction

  // Result number idx of a burst of the given kind.
  function automatic step_t burst_step(input burst_kind_t kind,
                                       input logic [STEP_W-1:0] idx);
    step_t s;
    s = step_status(ST_NOT_VALID);
    case (kind)
      K_UNLOCK: begin
        case (idx)
          3'd0:    s = step_write(CMD_LOCK_SETUP, 1'b0, ST_WORKING);
          3'd1:    s = step_write(CMD_CONFIRM, 1'b0, ST_WORKING);
          default: s = step_write(CMD_READ_ARRAY, 1'b1, ST_DONE);
        endcase
      end
      K_ERASE: begin
        case (idx)
          3'd0:    s = step_write(CMD_LOCK_SETUP, 1'b0, ST_WORKING);
          3'd1:    s = step_write(CMD_CONFIRM, 1'b0, ST_WORKING);
          3'd2:    s = step_write(CMD_CLEAR_STATUS, 1'b0, ST_WORKING);
          3'd3:    s = step_write(CMD_ERASE, 1'b0, ST_WORKING);
          3'd4:    s = step_write(CMD_CONFIRM, 1'b0, ST_WORKING);
          3'd5:    s = step_write(CMD_READ_STATUS, 1'b0, ST_WORKING);
          default: s = step_read();
        endcase
      end
      K_PROG_WR: begin
        case (idx)
          3'd0:    s = step_write(CMD_LOCK_SETUP, 1'b0, ST_WORKING);
          3'd1:    s = step_write(CMD_CONFIRM, 1'b0, ST_WORKING);
          3'd2:    s = step_write(CMD_CLEAR_STATUS, 1'b0, ST_WORKING);
          3'd3:    s = step_write(CMD_PROGRAM, 1'b0, ST_WORKING);
          3'd4:    s = step_value();
          default: s = step_read();
        endcase
      end
      K_SUSPEND: begin
        case (idx)
          3'd0:    s = step_write(CMD_SUSPEND, 1'b0, ST_WORKING);
          3'd1:    s = step_write(CMD_READ_STATUS, 1'b0, ST_WORKING);
          default: s = step_read();
        endcase
      end
      K_RESUME: begin
        case (idx)
          3'd0:    s = step_write(CMD_CONFIRM, 1'b0, ST_WORKING);
          3'd1:    s = step_write(CMD_READ_STATUS, 1'b0, ST_WORKING);
          default: s = step_read();
        endcase
      end
      K_PROG_READ: s = step_read();
      K_POLL:      s = step_read();
      K_REJECT:    s = step_status(ST_REJECTED);
      K_DONE:      s = step_write(CMD_READ_ARRAY, 1'b1, ST_DONE);
      K_SUSP_HOLD: s = step_write(CMD_READ_ARRAY, 1'b1, ST_SUSPENDED);
      default:     s = step_status(ST_NOT_VALID);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* design/nfcs_front.sv */
// ----------------------------------------------------------------------------
// NOR flash command sequencer front end
// Holds the configuration and the sequencer phase, and decodes every accepted
// item into one burst descriptor for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcs_front
  import nfcs_pkg::*;
#(
  parameter int ADDR_BITS   = ADDR_BITS_DEFAULT,
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [FLASH_ADDR_W-1:0] cfg_data,
  input  wire logic                    accept,
  input  wire in_item_t                item,
  output burst_t                       burst
);

  phase_t                  phase;
  phase_t                  phase_next;
  logic [FLASH_ADDR_W-1:0] flash_base;
  logic [SHIFT_W-1:0]      block_word_shift;
  logic [FLASH_ADDR_W-1:0] target_address;
  logic [FLASH_ADDR_W-1:0] target_address_next;
  logic [WORD_W-1:0]       pending_value;
  logic [WORD_W-1:0]       pending_value_next;
  burst_kind_t             kind;

  logic [ADDR_BITS-1:0]    block_offset;
  logic [ADDR_BITS-1:0]    block_sum;
  logic [FLASH_ADDR_W-1:0] block_address;
  logic [FLASH_ADDR_W-1:0] program_address;
  logic                    block_ok;
  logic                    would_set_bit;

  // Address arithmetic is done in ADDR_BITS width, then fit to the flash address field.
  always_comb begin
    block_offset    = ADDR_BITS'(item.block_number) << block_word_shift;
    block_sum       = ADDR_BITS'(flash_base) + block_offset;
    block_address   = FLASH_ADDR_W'(block_sum);
    program_address = FLASH_ADDR_W'(ADDR_BITS'(item.word_address));
    block_ok        = ({1'b0, item.block_number} < 9'(BLOCK_COUNT));
    would_set_bit   = |(~item.read_data & pending_value);
  end

  // Decode the item against the current phase.
  always_comb begin
    kind                = K_BAD;
    phase_next          = phase;
    target_address_next = target_address;
    pending_value_next  = pending_value;
    case (item.op)
      OP_UNLOCK, OP_ERASE: begin
        if (phase == PH_IDLE && block_ok) begin
          target_address_next = block_address;
          if (item.op == OP_UNLOCK) begin
            kind = K_UNLOCK;
          end else begin
            kind       = K_ERASE;
            phase_next = PH_ERASE_POLL;
          end
        end
      end
      OP_PROGRAM: begin
        if (phase == PH_IDLE) begin
          target_address_next = program_address;
          pending_value_next  = item.write_value;
          kind                = K_PROG_READ;
          phase_next          = PH_PROG_CHECK;
        end
      end
      OP_READ_REPLY: begin
        case (phase)
          PH_PROG_CHECK: begin
            if (would_set_bit) begin
              kind       = K_REJECT;
              phase_next = PH_IDLE;
            end else begin
              kind       = K_PROG_WR;
              phase_next = PH_PROG_POLL;
            end
          end
          PH_PROG_POLL: begin
            if (item.read_data[SR_READY_BIT]) begin
              kind       = K_DONE;
              phase_next = PH_IDLE;
            end else begin
              kind = K_POLL;
            end
          end
          PH_ERASE_POLL: begin
            if (item.read_data[SR_READY_BIT]) begin
              kind       = K_DONE;
              phase_next = PH_IDLE;
            end else if (item.irq_pending) begin
              kind       = K_SUSPEND;
              phase_next = PH_SUSP_POLL;
            end else begin
              kind = K_POLL;
            end
          end
          PH_SUSP_POLL: begin
            if (!item.read_data[SR_READY_BIT]) begin
              kind = K_POLL;
            end else if (!item.read_data[SR_SUSPEND_BIT]) begin
              // The erase finished before the suspend took hold.
              kind       = K_DONE;
              phase_next = PH_IDLE;
            end else begin
              kind       = K_SUSP_HOLD;
              phase_next = PH_SUSPENDED;
            end
          end
          default: kind = K_BAD;
        endcase
      end
      OP_RESUME: begin
        if (phase == PH_SUSPENDED) begin
          kind       = K_RESUME;
          phase_next = PH_ERASE_POLL;
        end
      end
      default: kind = K_BAD;
    endcase
  end

  // The descriptor carries the address and value that the burst will use.
  always_comb begin
    burst.kind    = kind;
    burst.address = target_address_next;
    burst.value   = pending_value_next;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_base       <= '0;
      block_word_shift <= BLOCK_SHIFT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_FLASH_BASE) begin
        flash_base <= cfg_data;
      end else if (cfg_index == REG_BLOCK_SHIFT) begin
        block_word_shift <= cfg_data[SHIFT_W-1:0];
      end
    end
  end

  // Sequencer state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      target_address <= '0;
      pending_value  <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      target_address <= target_address_next;
      pending_value  <= pending_value_next;
    end
  end

endmodule

`default_nettype wire

/* design/nfcs_queue.sv */
// ----------------------------------------------------------------------------
// NOR flash command sequencer burst queue
// Short first-in first-out store of decoded bursts between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcs_queue
  import nfcs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire burst_t push_data,
  input  wire logic   pop,
  output burst_t      head,
  output logic        empty,
  output logic        full
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  burst_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  always_comb begin
    empty = (count == '0);
    full  = (count == COUNT_W'(QUEUE_DEPTH));
    head  = entries[rd_ptr];
  end

  // Storage needs no reset; only the pointers and the count do.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/nfcs_back.sv */
// ----------------------------------------------------------------------------
// NOR flash command sequencer back end
// Expands the burst at the queue head into bus results, one per cycle while
// the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nfcs_back
  import nfcs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire burst_t                   head,
  input  wire logic                     empty,
  output logic                          pop,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          bus_is_write,
  output logic [FLASH_ADDR_W-1:0]       bus_address,
  output logic [WORD_W-1:0]             bus_data,
  output logic [STATUS_W-1:0]           status,
  output logic                          last,
  output logic                          has_access
);

  logic [STEP_W-1:0] idx;
  step_t             step;
  logic              load;

  // The output register takes a new result when it is empty or being drained.
  always_comb begin
    step = burst_step(head.kind, idx);
    load = (!out_valid || out_ready) && !empty;
    pop  = load && step.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= step.last ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      bus_is_write <= step.is_write;
      bus_address  <= step.has_access ? head.address : '0;
      bus_data     <= step.use_value ? head.value : {8'h00, step.cmd};
      status       <= step.status;
      last         <= step.last;
      has_access   <= step.has_access;
    end
  end

endmodule

`default_nettype wire

/* design/nor_flash_command_sequencer.sv */
// ----------------------------------------------------------------------------
// NOR flash command sequencer
// Turns unlock, program, erase and resume requests and flash read replies
// into the bus accesses of a 16-bit block-locking NOR flash command set.
//
//   Channel  Direction  Handshake         Payload
//   s_*      in         tvalid/tready     requests and read replies
//   m_*      out        tvalid/tready     bus accesses and status, tlast ends
//   cfg_*    in         valid/ready       register index and write data
//
// Each accepted item is decoded in the cycle it arrives and takes one queue
// slot; its first result goes from that queue slot into the output register,
// not straight from the decoder. The output register emits one result per
// cycle while m_tready is high, and an item yields one to seven results
// (seven for an erase start). The input accepts an item every cycle while the
// burst queue has room, even when the output stalls. Reset is synchronous,
// holds both input channels off while it is high, and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nor_flash_command_sequencer
  import nfcs_pkg::*;
#(
  parameter int ADDR_BITS   = ADDR_BITS_DEFAULT,
  parameter int BLOCK_COUNT = BLOCK_COUNT_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  // word_address[23:0], write_value[39:24], block_number[47:40],
  // read_data[63:48], irq_pending[64], zero[71:65]
  input  wire logic [71:0]             s_tdata,
  // op[2:0]
  input  wire logic [OP_W-1:0]         s_tuser,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // bus_is_write[0], bus_address[24:1], bus_data[40:25], zero[47:41]
  output logic [47:0]                  m_tdata,
  // status[2:0], has_access[3]
  output logic [3:0]                   m_tuser,
  output logic                         m_tlast,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [FLASH_ADDR_W-1:0] cfg_data
);

  in_item_t                item;
  burst_t                  burst;
  burst_t                  head;
  logic                    accept;
  logic                    q_empty;
  logic                    q_full;
  logic                    q_pop;
  logic                    bus_is_write;
  logic [FLASH_ADDR_W-1:0] bus_address;
  logic [WORD_W-1:0]       bus_data;
  logic [STATUS_W-1:0]     status;
  logic                    has_access;

  // Unpack the input transfer.
  always_comb begin
    item.op           = s_tuser;
    item.word_address = s_tdata[23:0];
    item.write_value  = s_tdata[39:24];
    item.block_number = s_tdata[47:40];
    item.read_data    = s_tdata[63:48];
    item.irq_pending  = s_tdata[64];
    s_tready          = !q_full && !rst;
    accept            = s_tvalid && s_tready;
    cfg_ready         = !rst;
  end

  nfcs_front #(
    .ADDR_BITS   (ADDR_BITS),
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (item),
    .burst     (burst)
  );

  nfcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (burst),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  nfcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (q_empty),
    .pop          (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .bus_is_write (bus_is_write),
    .bus_address  (bus_address),
    .bus_data     (bus_data),
    .status       (status),
    .last         (m_tlast),
    .has_access   (has_access)
  );

  // Pack the output transfer.
  always_comb begin
    m_tdata = {7'd0, bus_data, bus_address, bus_is_write};
    m_tuser = {has_access, status};
  end

endmodule

`default_nettype wire

/* sim/nor_flash_command_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// NOR flash command sequencer testbench
// Plays both the host and the flash: requests and read replies go in on the
// input stream, and every bus access and status that comes out is checked
// against a cycle-free model of the command sequencer. Runs a directed
// sequence, then random program, erase and unlock flows with out-of-turn
// requests mixed in, under several block-address register settings.
// ----------------------------------------------------------------------------

module nor_flash_command_sequencer_tb;
  import nfcs_pkg::*;

  // Request codes with no meaning to the sequencer.
  localparam logic [OP_W-1:0] OP_RESERVED_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RESERVED_7 = 3'd7;

  localparam int IDLE_PERCENT     = 11;
  localparam int CALM_FROM        = 250;
  localparam int CALM_TO          = 330;
  localparam int HOLD_AFTER_ITEMS = 120;
  localparam int HOLD_CYCLES      = 300;
  localparam int SETTLE_CYCLES    = 8;
  localparam int SETTINGS_COUNT   = 8;
  localparam int RANDOM_ITEMS     = 444;
  // Longest legal quiet spell is the output hold-off plus a few random stalls.
  localparam int HANG_LIMIT       = 3000;

  // What the host expects the flash to be doing, for shaping the stream.
  typedef enum logic [1:0] {
    FLOW_IDLE,
    FLOW_READING,
    FLOW_SUSPENDED
  } flow_t;

  // One bus access or status as it leaves the sequencer.
  typedef struct packed {
    logic                    is_write;
    logic [FLASH_ADDR_W-1:0] address;
    logic [WORD_W-1:0]       data;
    logic [STATUS_W-1:0]     status;
    logic                    last;
    logic                    has_access;
  } bus_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [71:0]             s_tdata = '0;
  logic [OP_W-1:0]         s_tuser = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [47:0]             m_tdata;
  logic [3:0]              m_tuser;
  logic                    m_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [FLASH_ADDR_W-1:0] cfg_data = '0;

  in_item_t    host_items[$];
  bus_result_t expected_accesses[$];
  in_item_t    offered_item;
  int          queued_items = 0;
  int          accepted_items = 0;
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  // Model copy of the sequencer state and its registers.
  phase_t                  seq_phase = PH_IDLE;
  logic [FLASH_ADDR_W-1:0] seq_target = '0;
  logic [WORD_W-1:0]       seq_value = '0;
  logic [FLASH_ADDR_W-1:0] cfg_base = '0;
  logic [SHIFT_W-1:0]      cfg_shift = BLOCK_SHIFT_RESET;

  wire calm = accepted_items >= CALM_FROM && accepted_items < CALM_TO;

  nor_flash_command_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Expected bus traffic builders.
  function automatic void expect_write(input logic [WORD_W-1:0] data,
                                       input logic [STATUS_W-1:0] status);
    expected_accesses.push_back('{is_write: 1'b1, address: seq_target, data: data,
                                  status: status, last: 1'b0, has_access: 1'b1});
  endfunction

  function automatic void expect_read();
    expected_accesses.push_back('{is_write: 1'b0, address: seq_target, data: '0,
                                  status: ST_WORKING, last: 1'b0, has_access: 1'b1});
  endfunction

  function automatic void expect_status(input logic [STATUS_W-1:0] status);
    expected_accesses.push_back('{is_write: 1'b0, address: '0, data: '0,
                                  status: status, last: 1'b0, has_access: 1'b0});
  endfunction

  // Work out the bus accesses that one accepted transfer causes.
  function automatic void advance_sequencer(input in_item_t it);
    logic [47:0] span;
    logic        bad;
    bad = 1'b0;
    case (it.op)
      OP_UNLOCK, OP_ERASE: begin
        if (seq_phase != PH_IDLE || int'(it.block_number) >= BLOCK_COUNT_DEFAULT) begin
          bad = 1'b1;
        end else begin
          // Block address wraps at ADDR_BITS, which equals the field width.
          span = 48'(cfg_base) + (48'(it.block_number) << cfg_shift);
          span = span & ((48'd1 << ADDR_BITS_DEFAULT) - 48'd1);
          seq_target = span[FLASH_ADDR_W-1:0];
          expect_write(CMD_LOCK_SETUP, ST_WORKING);
          expect_write(CMD_CONFIRM, ST_WORKING);
          if (it.op == OP_UNLOCK) begin
            expect_write(CMD_READ_ARRAY, ST_DONE);
          end else begin
            expect_write(CMD_CLEAR_STATUS, ST_WORKING);
            expect_write(CMD_ERASE, ST_WORKING);
            expect_write(CMD_CONFIRM, ST_WORKING);
            expect_write(CMD_READ_STATUS, ST_WORKING);
            expect_read();
            seq_phase = PH_ERASE_POLL;
          end
        end
      end
      OP_PROGRAM: begin
        if (seq_phase != PH_IDLE) begin
          bad = 1'b1;
        end else begin
          seq_target = it.word_address;
          seq_value = it.write_value;
          expect_read();
          seq_phase = PH_PROG_CHECK;
        end
      end
      OP_READ_REPLY: begin
        case (seq_phase)
          PH_PROG_CHECK: begin
            // A program can only clear bits.
            if ((~it.read_data & seq_value) != '0) begin
              expect_status(ST_REJECTED);
              seq_phase = PH_IDLE;
            end else begin
              expect_write(CMD_LOCK_SETUP, ST_WORKING);
              expect_write(CMD_CONFIRM, ST_WORKING);
              expect_write(CMD_CLEAR_STATUS, ST_WORKING);
              expect_write(CMD_PROGRAM, ST_WORKING);
              expect_write(seq_value, ST_WORKING);
              expect_read();
              seq_phase = PH_PROG_POLL;
            end
          end
          PH_PROG_POLL: begin
            if (it.read_data[SR_READY_BIT]) begin
              expect_write(CMD_READ_ARRAY, ST_DONE);
              seq_phase = PH_IDLE;
            end else begin
              expect_read();
            end
          end
          PH_ERASE_POLL: begin
            if (it.read_data[SR_READY_BIT]) begin
              expect_write(CMD_READ_ARRAY, ST_DONE);
              seq_phase = PH_IDLE;
            end else if (it.irq_pending) begin
              expect_write(CMD_SUSPEND, ST_WORKING);
              expect_write(CMD_READ_STATUS, ST_WORKING);
              expect_read();
              seq_phase = PH_SUSP_POLL;
            end else begin
              expect_read();
            end
          end
          PH_SUSP_POLL: begin
            if (!it.read_data[SR_READY_BIT]) begin
              expect_read();
            end else if (!it.read_data[SR_SUSPEND_BIT]) begin
              // The erase finished before the suspend took hold.
              expect_write(CMD_READ_ARRAY, ST_DONE);
              seq_phase = PH_IDLE;
            end else begin
              expect_write(CMD_READ_ARRAY, ST_SUSPENDED);
              seq_phase = PH_SUSPENDED;
            end
          end
          default: bad = 1'b1;
        endcase
      end
      OP_RESUME: begin
        if (seq_phase != PH_SUSPENDED) begin
          bad = 1'b1;
        end else begin
          expect_write(CMD_CONFIRM, ST_WORKING);
          expect_write(CMD_READ_STATUS, ST_WORKING);
          expect_read();
          seq_phase = PH_ERASE_POLL;
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) expect_status(ST_NOT_VALID);
    expected_accesses[expected_accesses.size()-1].last = 1'b1;
  endfunction

  // Stimulus builders.
  function automatic in_item_t make_item(input logic [OP_W-1:0] op);
    in_item_t it;
    it.op = op;
    it.word_address = FLASH_ADDR_W'($urandom);
    it.write_value = WORD_W'($urandom);
    it.block_number = BLOCK_W'($urandom);
    it.read_data = WORD_W'($urandom);
    it.irq_pending = 1'($urandom);
    return it;
  endfunction

  function automatic void queue_item(input in_item_t it);
    host_items.push_back(it);
    queued_items++;
  endfunction

  function automatic void queue_request(input logic [OP_W-1:0] op,
                                        input logic [FLASH_ADDR_W-1:0] address,
                                        input logic [WORD_W-1:0] value,
                                        input logic [BLOCK_W-1:0] block);
    in_item_t it;
    it = make_item(op);
    it.word_address = address;
    it.write_value = value;
    it.block_number = block;
    queue_item(it);
  endfunction

  function automatic void queue_reply(input logic [WORD_W-1:0] data, input logic irq);
    in_item_t it;
    it = make_item(OP_READ_REPLY);
    it.read_data = data;
    it.irq_pending = irq;
    queue_item(it);
  endfunction

  // Random status word with the ready bit forced.
  function automatic logic [WORD_W-1:0] poll_word(input logic ready);
    logic [WORD_W-1:0] w;
    w = WORD_W'($urandom);
    w[SR_READY_BIT] = ready;
    return w;
  endfunction

  // A request or reply that does not fit the current flow.
  function automatic void queue_noise(input flow_t flow);
    logic [OP_W-1:0] op;
    do op = OP_W'($urandom_range(0, 7));
    while ((flow == FLOW_IDLE && op inside {OP_UNLOCK, OP_PROGRAM, OP_ERASE}) ||
           (flow == FLOW_READING && op == OP_READ_REPLY) ||
           (flow == FLOW_SUSPENDED && op == OP_RESUME));
    queue_item(make_item(op));
  endfunction

  function automatic void maybe_noise(input flow_t flow);
    if ($urandom_range(0, 99) < 8) queue_noise(flow);
  endfunction

  function automatic void queue_program_random();
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] stored;
    int                b;
    value = WORD_W'($urandom);
    queue_request(OP_PROGRAM, FLASH_ADDR_W'($urandom), value, BLOCK_W'($urandom));
    maybe_noise(FLOW_READING);
    stored = WORD_W'($urandom) | value;
    // Now and then the word holds a 0 where a 1 is asked for.
    if (value != '0 && $urandom_range(0, 3) == 0) begin
      do b = $urandom_range(0, WORD_W - 1);
      while (!value[b]);
      stored[b] = 1'b0;
    end
    queue_reply(stored, 1'($urandom));
    if ((~stored & value) == '0) begin
      repeat ($urandom_range(0, 2)) begin
        maybe_noise(FLOW_READING);
        queue_reply(poll_word(1'b0), 1'($urandom));
      end
      maybe_noise(FLOW_READING);
      queue_reply(poll_word(1'b1), 1'($urandom));
    end
  endfunction

  function automatic void queue_erase_random();
    logic [WORD_W-1:0] w;
    int                rounds;
    bit                running;
    queue_request(OP_ERASE, FLASH_ADDR_W'($urandom), WORD_W'($urandom), BLOCK_W'($urandom));
    running = 1'b1;
    rounds = 0;
    while (running) begin
      repeat ($urandom_range(0, 2)) begin
        maybe_noise(FLOW_READING);
        queue_reply(poll_word(1'b0), 1'b0);
      end
      maybe_noise(FLOW_READING);
      rounds++;
      if (rounds > 3 || $urandom_range(0, 2) == 0) begin
        queue_reply(poll_word(1'b1), 1'($urandom));
        running = 1'b0;
      end else begin
        // Interrupt at a busy poll: suspend, then poll the suspend.
        queue_reply(poll_word(1'b0), 1'b1);
        repeat ($urandom_range(0, 1)) queue_reply(poll_word(1'b0), 1'($urandom));
        w = poll_word(1'b1);
        if ($urandom_range(0, 3) == 0) begin
          w[SR_SUSPEND_BIT] = 1'b0;
          queue_reply(w, 1'($urandom));
          running = 1'b0;
        end else begin
          w[SR_SUSPEND_BIT] = 1'b1;
          queue_reply(w, 1'($urandom));
          repeat ($urandom_range(0, 2)) queue_noise(FLOW_SUSPENDED);
          queue_request(OP_RESUME, FLASH_ADDR_W'($urandom), WORD_W'($urandom),
                        BLOCK_W'($urandom));
        end
      end
    end
  endfunction

  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [FLASH_ADDR_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == REG_FLASH_BASE) cfg_base = data;
    else cfg_shift = data[SHIFT_W-1:0];
  endtask

  // Wait until every queued transfer went in and every result came out.
  task automatic wait_idle();
    while (accepted_items != queued_items || expected_accesses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input side: offer queued transfers, idling now and then.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        advance_sequencer(offered_item);
        accepted_items <= accepted_items + 1;
      end
      if (host_items.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        offered_item = host_items.pop_front();
        s_tdata <= {7'd0, offered_item.irq_pending, offered_item.read_data,
                    offered_item.block_number, offered_item.write_value,
                    offered_item.word_address};
        s_tuser <= offered_item.op;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random stalls plus one long hold-off to fill the block up.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_items >= HOLD_AFTER_ITEMS) begin
      m_tready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      m_tready <= calm || $urandom_range(0, 99) >= IDLE_PERCENT;
    end
  end

  function automatic void check_field(input string field, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result transfer with the oldest expected one.
  always @(posedge clk) begin
    bus_result_t got;
    bus_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{is_write: m_tdata[0], address: m_tdata[24:1], data: m_tdata[40:25],
              status: m_tuser[2:0], last: m_tlast, has_access: m_tuser[3]};
      if (expected_accesses.size() == 0) begin
        $display("%0t: result with nothing expected: write %0b address 0x%0h data 0x%0h",
                 $time, got.is_write, got.address, got.data);
        mismatches++;
      end else begin
        want = expected_accesses.pop_front();
        check_field("bus_is_write", 24'(want.is_write), 24'(got.is_write));
        check_field("bus_address", want.address, got.address);
        check_field("bus_data", 24'(want.data), 24'(got.data));
        check_field("status", 24'(want.status), 24'(got.status));
        check_field("last", 24'(want.last), 24'(got.last));
        check_field("has_access", 24'(want.has_access), 24'(got.has_access));
      end
    end
  end

  // Watchdog: too long without any transfer on any channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == HANG_LIMIT) begin
      $display("nor_flash_command_sequencer_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [FLASH_ADDR_W-1:0] base;
    logic [SHIFT_W-1:0]      shift;
    int                      goal;
    int                      pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < SETTINGS_COUNT; p++) begin
      wait_idle();
      case (p)
        0: begin
          base = '0;
          shift = BLOCK_SHIFT_RESET;
        end
        1: begin
          base = '1;
          shift = 5'd20;
        end
        2: begin
          base = '0;
          shift = 5'd8;
        end
        default: begin
          base = FLASH_ADDR_W'($urandom);
          shift = SHIFT_W'($urandom_range(8, 20));
        end
      endcase
      write_register(REG_FLASH_BASE, base);
      write_register(REG_BLOCK_SHIFT, FLASH_ADDR_W'(shift));
      if (p == 0) begin
        // Directed flows under the reset register values.
        queue_request(OP_UNLOCK, 24'h000000, 16'h0000, 8'd0);
        queue_request(OP_ERASE, 24'hFFFFFF, 16'hFFFF, 8'd255);
        queue_reply(16'h0000, 1'b0);
        queue_reply(16'h0000, 1'b1);
        queue_reply(16'h00C0, 1'b0);
        // A new request while suspended is refused.
        queue_request(OP_ERASE, 24'h000000, 16'h0000, 8'd3);
        queue_request(OP_RESUME, 24'h000000, 16'h0000, 8'd0);
        // Ready wins over a pending interrupt.
        queue_reply(16'hFFFF, 1'b1);
        queue_request(OP_PROGRAM, 24'hFFFFFF, 16'hFFFF, 8'd255);
        queue_reply(16'hFFFF, 1'b0);
        queue_reply(16'hFF7F, 1'b0);
        queue_reply(16'h0080, 1'b0);
        // Program that would set a cleared bit.
        queue_request(OP_PROGRAM, 24'h000000, 16'h0001, 8'd0);
        queue_reply(16'hFFFE, 1'b0);
        queue_request(OP_PROGRAM, 24'h000000, 16'h0000, 8'd0);
        queue_reply(16'h0000, 1'b0);
        queue_request(OP_UNLOCK, 24'h000000, 16'h0000, 8'd1);
        queue_reply(16'h0080, 1'b0);
        // Erase that completes while the suspend is being polled.
        queue_request(OP_ERASE, 24'h000000, 16'h0000, 8'd0);
        queue_reply(16'h0000, 1'b1);
        queue_reply(16'h0080, 1'b0);
        // Stray reply, stray resume and the unused request codes.
        queue_reply(16'hFFFF, 1'b1);
        queue_request(OP_RESUME, 24'h000000, 16'h0000, 8'd0);
        queue_item(make_item(OP_RESERVED_5));
        queue_item(make_item(OP_RESERVED_6));
        queue_item(make_item(OP_RESERVED_7));
      end else begin
        goal = queued_items + RANDOM_ITEMS / (SETTINGS_COUNT - 1);
        while (queued_items < goal) begin
          pick = $urandom_range(0, 99);
          if (pick < 35) queue_program_random();
          else if (pick < 75) queue_erase_random();
          else if (pick < 90) queue_request(OP_UNLOCK, FLASH_ADDR_W'($urandom),
                                            WORD_W'($urandom), BLOCK_W'($urandom));
          else queue_noise(FLOW_IDLE);
        end
      end
    end
    wait_idle();
    if (mismatches == 0) begin
      $display("nor_flash_command_sequencer_tb: done, clean");
    end else begin
      $display("nor_flash_command_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule
